FILE: rtl/psw_pkg.sv
// ----------------------------------------------------------------------------
// psw_pkg
// Shared types, command codes, time constants and reciprocal constants for
// the pausable stopwatch and its breakdown pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package psw_pkg;

  // time base constants
  localparam int unsigned USEC_PER_SEC = 1000000;
  localparam int unsigned SEC_PER_DAY  = 86400;
  localparam int unsigned SEC_PER_HOUR = 3600;
  localparam int unsigned SEC_PER_MIN  = 60;

  localparam logic [19:0] USEC_WRAP = 20'(USEC_PER_SEC);
  localparam logic [19:0] USEC_MAX  = 20'(USEC_PER_SEC - 1);

  // remainder widths after whole days and whole hours
  localparam int unsigned REM_DAY_W  = 17;
  localparam int unsigned REM_HOUR_W = 12;

  // days: drop the power-of-two factor, then multiply by a rounded-up reciprocal
  localparam int unsigned DAY_PRE   = 7;
  localparam int unsigned DAY_ODD   = SEC_PER_DAY >> DAY_PRE;
  localparam int unsigned DAY_SHIFT = 35;
  localparam longint unsigned DAY_MAGIC_FULL =
      ((64'd1 << DAY_SHIFT) + 64'(DAY_ODD) - 64'd1) / 64'(DAY_ODD);
  localparam logic [25:0] DAY_MAGIC = 26'(DAY_MAGIC_FULL);

  // hours from the remainder after whole days
  localparam int unsigned HOUR_PRE   = 4;
  localparam int unsigned HOUR_ODD   = SEC_PER_HOUR >> HOUR_PRE;
  localparam int unsigned HOUR_SHIFT = 21;
  localparam longint unsigned HOUR_MAGIC_FULL =
      ((64'd1 << HOUR_SHIFT) + 64'(HOUR_ODD) - 64'd1) / 64'(HOUR_ODD);
  localparam logic [13:0] HOUR_MAGIC = 14'(HOUR_MAGIC_FULL);

  // minutes from the remainder after whole hours
  localparam int unsigned MIN_SHIFT = 18;
  localparam longint unsigned MIN_MAGIC_FULL =
      ((64'd1 << MIN_SHIFT) + 64'(SEC_PER_MIN) - 64'd1) / 64'(SEC_PER_MIN);
  localparam logic [12:0] MIN_MAGIC = 13'(MIN_MAGIC_FULL);

  // command codes
  typedef enum logic [2:0] {
    CMD_QUERY = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_RESET = 3'd3,
    CMD_PAUSE = 3'd4
  } cmd_t;

  typedef struct packed {
    logic [31:0] sec;
    logic [19:0] usec;
  } stamp_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] now_sec;
    logic [19:0] now_usec;
  } in_item_t;

  typedef struct packed {
    logic        running;
    logic        held;
    logic [31:0] elapsed_sec;
    logic [19:0] elapsed_usec;
    logic [15:0] part_days;
    logic [4:0]  part_hours;
    logic [5:0]  part_minutes;
    logic [5:0]  part_seconds;
  } out_item_t;

  // flags and marks after the command, travelling with the current time
  typedef struct packed {
    logic   running;
    logic   held;
    stamp_t now;
    stamp_t mark;
    stamp_t hold;
  } track_t;

  // elapsed time with the registered day product
  typedef struct packed {
    logic        running;
    logic        held;
    stamp_t      elap;
    logic [50:0] day_prod;
  } elapsed_t;

  // saturating difference a - b, microseconds of b below one million
  function automatic stamp_t time_diff(stamp_t a, stamp_t b);
    stamp_t r;
    logic   later;
    logic   borrow;
    later  = {a.sec, a.usec} > {b.sec, b.usec};
    borrow = a.usec < b.usec;
    r.sec  = a.sec - b.sec - {31'd0, borrow};
    r.usec = a.usec - b.usec + (borrow ? USEC_WRAP : 20'd0);
    if (!later) begin
      r = '0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/psw_track.sv
// ----------------------------------------------------------------------------
// psw_track
// Input register, stopwatch state and command decode; passes the updated
// flags and marks on with the current time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module psw_track
  import psw_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire in_item_t in_item,
  input  wire logic     load_in,
  input  wire logic     load_trk,
  input  wire logic     step,
  output track_t        trk
);

  in_item_t cap;
  stamp_t   now;
  logic     is_running;
  logic     is_held;
  stamp_t   mark;
  stamp_t   hold;

  logic     is_running_next;
  logic     is_held_next;
  stamp_t   mark_next;
  stamp_t   hold_next;
  stamp_t   delta;

  // input register, microseconds clamped below one second
  always_ff @(posedge clk) begin
    if (load_in) begin
      cap.cmd      <= in_item.cmd;
      cap.now_sec  <= in_item.now_sec;
      cap.now_usec <= (in_item.now_usec > USEC_MAX) ? USEC_MAX : in_item.now_usec;
    end
  end

  assign now.sec  = cap.now_sec;
  assign now.usec = cap.now_usec;

  // one shared difference: resume subtracts the held time, pause the start mark
  assign delta = time_diff(now, is_held ? hold : mark);

  // command decode
  always_comb begin
    is_running_next = is_running;
    is_held_next    = is_held;
    mark_next       = mark;
    hold_next       = hold;
    unique case (cap.cmd)
      CMD_START: begin
        if (is_held) begin
          is_held_next = 1'b0;
          mark_next    = delta;
        end else begin
          is_running_next = 1'b1;
          mark_next       = now;
        end
      end
      CMD_STOP: begin
        is_running_next = 1'b0;
        is_held_next    = 1'b0;
      end
      CMD_RESET: begin
        is_running_next = 1'b1;
        is_held_next    = 1'b0;
        mark_next       = now;
      end
      CMD_PAUSE: begin
        if (is_running && !is_held) begin
          is_held_next = 1'b1;
          hold_next    = delta;
        end
      end
      default: begin
      end
    endcase
  end

  // stopwatch state, updated as a transaction leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      is_running <= 1'b0;
      is_held    <= 1'b0;
      mark       <= '0;
      hold       <= '0;
    end else if (step) begin
      is_running <= is_running_next;
      is_held    <= is_held_next;
      mark       <= mark_next;
      hold       <= hold_next;
    end
  end

  // snapshot after the command
  always_ff @(posedge clk) begin
    if (load_trk) begin
      trk.running <= is_running_next;
      trk.held    <= is_held_next;
      trk.now     <= now;
      trk.mark    <= mark_next;
      trk.hold    <= hold_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/psw_elapsed.sv
// ----------------------------------------------------------------------------
// psw_elapsed
// Elapsed time from the snapshot, then the day reciprocal product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module psw_elapsed
  import psw_pkg::*;
(
  input  wire logic   clk,
  input  wire track_t trk,
  input  wire logic   load_elap,
  input  wire logic   load_prod,
  output elapsed_t    elp
);

  logic   run_q;
  logic   held_q;
  stamp_t elap;
  stamp_t elap_next;

  // held value while paused, zero while stopped
  always_comb begin
    if (!trk.running) begin
      elap_next = '0;
    end else if (trk.held) begin
      elap_next = trk.hold;
    end else begin
      elap_next = time_diff(trk.now, trk.mark);
    end
  end

  always_ff @(posedge clk) begin
    if (load_elap) begin
      run_q  <= trk.running;
      held_q <= trk.held;
      elap   <= elap_next;
    end
  end

  // whole days as a product with the reciprocal of the odd factor
  always_ff @(posedge clk) begin
    if (load_prod) begin
      elp.running  <= run_q;
      elp.held     <= held_q;
      elp.elap     <= elap;
      elp.day_prod <= 51'(elap.sec[31:DAY_PRE]) * 51'(DAY_MAGIC);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/psw_split.sv
// ----------------------------------------------------------------------------
// psw_split
// Breakdown of the elapsed seconds into days, hours, minutes and seconds,
// one reciprocal multiply or one back-multiply and subtract per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module psw_split
  import psw_pkg::*;
(
  input  wire logic     clk,
  input  wire elapsed_t elp,
  input  wire logic     load_day,
  input  wire logic     load_hprod,
  input  wire logic     load_hour,
  input  wire logic     load_mprod,
  input  wire logic     load_out,
  output out_item_t     out_item
);

  typedef struct packed {
    logic        running;
    logic        held;
    stamp_t      elap;
    logic [15:0] days;
  } carry_t;

  carry_t                  c4;
  carry_t                  c5;
  carry_t                  c6;
  carry_t                  c7;
  logic [REM_DAY_W-1:0]    rem_day4;
  logic [REM_DAY_W-1:0]    rem_day5;
  logic [26:0]             hr_prod;
  logic [4:0]              hours6;
  logic [4:0]              hours7;
  logic [REM_HOUR_W-1:0]   rem_hour6;
  logic [REM_HOUR_W-1:0]   rem_hour7;
  logic [24:0]             min_prod;
  logic [15:0]             days_next;
  logic [4:0]              hours_next;
  logic [5:0]              minutes_next;

  assign days_next    = 16'(elp.day_prod >> DAY_SHIFT);
  assign hours_next   = 5'(hr_prod >> HOUR_SHIFT);
  assign minutes_next = 6'(min_prod >> MIN_SHIFT);

  // whole days and the seconds left within the day
  always_ff @(posedge clk) begin
    if (load_day) begin
      c4.running <= elp.running;
      c4.held    <= elp.held;
      c4.elap    <= elp.elap;
      c4.days    <= days_next;
      rem_day4   <= REM_DAY_W'(elp.elap.sec - (32'(days_next) * SEC_PER_DAY));
    end
  end

  // hour reciprocal product
  always_ff @(posedge clk) begin
    if (load_hprod) begin
      c5       <= c4;
      rem_day5 <= rem_day4;
      hr_prod  <= 27'(rem_day4[REM_DAY_W-1:HOUR_PRE]) * 27'(HOUR_MAGIC);
    end
  end

  // whole hours and the seconds left within the hour
  always_ff @(posedge clk) begin
    if (load_hour) begin
      c6        <= c5;
      hours6    <= hours_next;
      rem_hour6 <= REM_HOUR_W'(rem_day5 - REM_DAY_W'(hours_next) * REM_DAY_W'(SEC_PER_HOUR));
    end
  end

  // minute reciprocal product
  always_ff @(posedge clk) begin
    if (load_mprod) begin
      c7        <= c6;
      hours7    <= hours6;
      rem_hour7 <= rem_hour6;
      min_prod  <= 25'(rem_hour6) * 25'(MIN_MAGIC);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_item.running      <= c7.running;
      out_item.held         <= c7.held;
      out_item.elapsed_sec  <= c7.elap.sec;
      out_item.elapsed_usec <= c7.elap.usec;
      out_item.part_days    <= c7.days;
      out_item.part_hours   <= hours7;
      out_item.part_minutes <= minutes_next;
      out_item.part_seconds <=
          6'(rem_hour7 - REM_HOUR_W'(minutes_next) * REM_HOUR_W'(SEC_PER_MIN));
    end
  end

endmodule

`default_nettype wire

FILE: rtl/pausable_stopwatch.sv
// ----------------------------------------------------------------------------
// pausable_stopwatch
// Stopwatch with start/resume, stop, reset and pause commands; every command
// returns the flags, the elapsed time and its day/hour/minute/second split.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+---------------------------------------
//   input    | in_valid / in_ready   | in_item  (cmd, now_sec, now_usec)
//   output   | out_valid / out_ready | out_item (flags, elapsed, breakdown)
//
// One transaction per cycle sustained while out_ready stays high; out_valid rises
// once the transaction has passed the nine register stages (input, state update,
// elapsed difference, three reciprocal products, two back-subtracts, result),
// the first of which loads at acceptance.
// Stopwatch state changes as a transaction leaves the input register, so a
// command sees every earlier one. Reset is synchronous and clears the flags,
// the marks and all stage valids. A stalled output holds its stage; earlier
// stages keep filling bubbles, so input is taken while a result waits until
// all nine stages hold a transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pausable_stopwatch
  import psw_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_item
);

  localparam int unsigned DEPTH = 9;

  logic [DEPTH-1:0] vld;
  logic [DEPTH:0]   adv;
  track_t           trk;
  elapsed_t         elp;

  // a stage may load when it is empty or its contents move on
  always_comb begin
    adv[DEPTH] = out_ready;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < DEPTH; i++) begin
        if (adv[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld[DEPTH-1];

  psw_track u_track (
    .clk      (clk),
    .rst      (rst),
    .in_item  (in_item),
    .load_in  (adv[0]),
    .load_trk (adv[1]),
    .step     (vld[0] && adv[1]),
    .trk      (trk)
  );

  psw_elapsed u_elapsed (
    .clk       (clk),
    .trk       (trk),
    .load_elap (adv[2]),
    .load_prod (adv[3]),
    .elp       (elp)
  );

  psw_split u_split (
    .clk        (clk),
    .elp        (elp),
    .load_day   (adv[4]),
    .load_hprod (adv[5]),
    .load_hour  (adv[6]),
    .load_mprod (adv[7]),
    .load_out   (adv[8]),
    .out_item   (out_item)
  );

  // a pause never outlives the running flag
  a_held_running: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_item.held || out_item.running))
    else $error("held result without running");

  // stopped stopwatch reports no elapsed time
  a_stopped_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_item.running) |->
      (out_item.elapsed_sec == 32'd0 && out_item.elapsed_usec == 20'd0))
    else $error("elapsed time while stopped");

  // breakdown fields within their ranges
  a_split_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.part_hours < 5'd24 && out_item.part_minutes < 6'd60 &&
                   out_item.part_seconds < 6'd60 && out_item.elapsed_usec < USEC_WRAP))
    else $error("breakdown out of range");

  // breakdown adds back up to the elapsed seconds
  a_split_sum: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((32'(out_item.part_days) * SEC_PER_DAY +
                    32'(out_item.part_hours) * SEC_PER_HOUR +
                    32'(out_item.part_minutes) * SEC_PER_MIN +
                    32'(out_item.part_seconds)) == out_item.elapsed_sec))
    else $error("breakdown does not match elapsed seconds");

  // an empty input stage always takes a transaction
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    (!vld[0] && out_valid && !out_ready) |-> in_ready)
    else $error("input refused while input register empty");

endmodule

`default_nettype wire

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for pausable_stopwatch. A directed run covers the field
// extremes, every command, the spare command codes, out-of-range microseconds
// and times that are not later than the mark. A long random run follows,
// mostly time moving forward with a random mix of commands plus some noise.
// It uses three idling mixes and one long output stall. Every accepted
// command is run through a behavioural copy of the stopwatch, and each
// returned reading is compared field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import psw_pkg::*;

  localparam int CYCLE_LIMIT  = 100000;
  localparam int LONG_STALL   = 300;
  localparam int DRAIN_CYCLES = 30;
  localparam int PHASE_ITEMS  = 540;

  // codes that the block treats as a query
  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  // behavioural stopwatch and the readings it expects back
  class stopwatch_scoreboard;
    logic      running;
    logic      held;
    stamp_t    mark;
    stamp_t    hold;
    out_item_t expected_readings[$];
    int        errors;

    function new();
      running = 1'b0;
      held    = 1'b0;
      mark    = '0;
      hold    = '0;
      errors  = 0;
    endfunction

    // a minus b, clamped to zero when a is not after b
    function stamp_t span(stamp_t a, stamp_t b);
      stamp_t r;
      r = '0;
      if (a.sec > b.sec || (a.sec == b.sec && a.usec > b.usec)) begin
        r.sec = a.sec - b.sec;
        if (a.usec < b.usec) begin
          r.sec  = r.sec - 32'd1;
          r.usec = 20'(a.usec + USEC_PER_SEC - b.usec);
        end else begin
          r.usec = a.usec - b.usec;
        end
      end
      return r;
    endfunction

    function void note_command(in_item_t it);
      stamp_t      now;
      stamp_t      elap;
      out_item_t   want;
      logic [31:0] rest;
      now.sec  = it.now_sec;
      now.usec = (it.now_usec > USEC_MAX) ? USEC_MAX : it.now_usec;
      case (cmd_t'(it.cmd))
        CMD_START: begin
          if (held) begin
            held = 1'b0;
            mark = span(now, hold);
          end else begin
            running = 1'b1;
            mark    = now;
          end
        end
        CMD_STOP: begin
          running = 1'b0;
          held    = 1'b0;
        end
        CMD_RESET: begin
          running = 1'b1;
          held    = 1'b0;
          mark    = now;
        end
        CMD_PAUSE: begin
          if (running && !held) begin
            held = 1'b1;
            hold = span(now, mark);
          end
        end
        default: ;
      endcase
      elap = '0;
      if (running) begin
        elap = held ? hold : span(now, mark);
      end
      // flags, elapsed time and its day/hour/minute/second split
      want.running      = running;
      want.held         = held;
      want.elapsed_sec  = elap.sec;
      want.elapsed_usec = elap.usec;
      want.part_days    = 16'(elap.sec / SEC_PER_DAY);
      rest              = elap.sec % SEC_PER_DAY;
      want.part_hours   = 5'(rest / SEC_PER_HOUR);
      rest              = rest % SEC_PER_HOUR;
      want.part_minutes = 6'(rest / SEC_PER_MIN);
      want.part_seconds = 6'(rest % SEC_PER_MIN);
      expected_readings.push_back(want);
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) begin
        report($sformatf("%s got %0d expected %0d", name, got, want));
      end
    endtask

    task check_reading(out_item_t got);
      out_item_t want;
      if (expected_readings.size() == 0) begin
        report("reading returned with no command outstanding");
        return;
      end
      want = expected_readings.pop_front();
      compare_field("running", 32'(got.running), 32'(want.running));
      compare_field("held", 32'(got.held), 32'(want.held));
      compare_field("elapsed_sec", got.elapsed_sec, want.elapsed_sec);
      compare_field("elapsed_usec", 32'(got.elapsed_usec), 32'(want.elapsed_usec));
      compare_field("part_days", 32'(got.part_days), 32'(want.part_days));
      compare_field("part_hours", 32'(got.part_hours), 32'(want.part_hours));
      compare_field("part_minutes", 32'(got.part_minutes), 32'(want.part_minutes));
      compare_field("part_seconds", 32'(got.part_seconds), 32'(want.part_seconds));
    endtask

    function int outstanding();
      return expected_readings.size();
    endfunction
  endclass

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  int          tx_idle_pct   = 0;
  int          rx_idle_pct   = 0;
  logic        stall_request = 1'b0;
  logic        stall_done    = 1'b0;
  int          cycle_count   = 0;
  logic [31:0] wall_sec      = '0;
  int unsigned wall_usec     = 0;

  stopwatch_scoreboard board = new();

  pausable_stopwatch dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // output side: random back-pressure, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (stall_request && !stall_done) begin
        out_ready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
        stall_done = 1'b1;
      end
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // check each returned reading
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      board.check_reading(out_item);
    end
  end

  // offer one command, with random gaps before it, and wait for the transaction
  task automatic send_command(in_item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_command(it);
  endtask

  task automatic send_fields(logic [2:0] code, logic [31:0] sec, logic [19:0] usec);
    in_item_t it;
    it.cmd      = code;
    it.now_sec  = sec;
    it.now_usec = usec;
    send_command(it);
  endtask

  // mostly a wall clock moving forward, sometimes an arbitrary time and code
  task automatic send_random_command();
    in_item_t    it;
    int          pick;
    int unsigned u;
    pick = $urandom_range(99);
    if (pick < 12) begin
      it.cmd      = 3'($urandom_range(7));
      it.now_sec  = $urandom;
      it.now_usec = 20'($urandom);
    end else begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: wall_sec += $urandom_range(3);
        6, 7:             wall_sec += $urandom_range(100000);
        8:                wall_sec += $urandom_range(4000000);
        default:          wall_sec += $urandom;
      endcase
      u = wall_usec + $urandom_range(USEC_PER_SEC - 1);
      if (u >= USEC_PER_SEC) begin
        u -= USEC_PER_SEC;
        wall_sec++;
      end
      wall_usec   = u;
      it.now_sec  = wall_sec;
      it.now_usec = 20'(wall_usec);
      pick = $urandom_range(99);
      if (pick < 30)      it.cmd = CMD_QUERY;
      else if (pick < 50) it.cmd = CMD_START;
      else if (pick < 60) it.cmd = CMD_STOP;
      else if (pick < 72) it.cmd = CMD_RESET;
      else if (pick < 95) it.cmd = CMD_PAUSE;
      else                it.cmd = 3'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
    end
    send_command(it);
  endtask

  task automatic wait_for_readings();
    while (board.outstanding() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    tx_idle_pct = 6;
    rx_idle_pct = 57;

    // directed: idle commands, borrow, huge elapsed, resume, clamps
    send_fields(CMD_QUERY, 32'd0, 20'd0);
    send_fields(CMD_PAUSE, 32'd0, 20'd0);
    send_fields(CMD_START, 32'd0, 20'd0);
    send_fields(CMD_QUERY, 32'd0, 20'd0);
    send_fields(CMD_QUERY, 32'd0, 20'd1);
    send_fields(CMD_QUERY, 32'd1, 20'd0);
    send_fields(CMD_PAUSE, 32'hFFFF_FFFF, USEC_MAX);
    send_fields(CMD_PAUSE, 32'd5, 20'd0);
    send_fields(CMD_QUERY, 32'd3, 20'hF_FFFF);
    send_fields(CMD_START, 32'hFFFF_FFFF, 20'hF_FFFF);
    send_fields(CMD_QUERY, 32'd100000, 20'd500000);
    send_fields(CMD_RESET, 32'd1000, USEC_MAX);
    send_fields(CMD_QUERY, 32'd999, 20'd0);
    send_fields(CMD_QUERY, 32'd91061, USEC_MAX);
    send_fields(CMD_PAUSE, 32'd2000, 20'd0);
    send_fields(CMD_START, 32'd500, 20'd0);
    send_fields(CMD_QUERY, 32'd86399, USEC_MAX);
    send_fields(CMD_STOP, 32'd5, 20'd5);
    send_fields(CMD_SPARE_LO, 32'd7, 20'd7);
    send_fields(CMD_SPARE_HI, 32'hFFFF_FFFF, 20'd0);
    send_fields(3'(CMD_SPARE_LO + 3'd1), 32'd8, 20'd8);
    send_fields(CMD_START, 32'hAAAA_AAAA, 20'h5_5555);
    send_fields(CMD_QUERY, 32'hFFFF_FFFF, 20'hA_AAAA);
    send_fields(CMD_RESET, 32'hFFFF_FFFF, USEC_MAX);
    send_fields(CMD_QUERY, 32'd0, 20'd0);
    send_fields(CMD_STOP, 32'h5555_5555, 20'hA_AAAA);

    // random phases: slow receiver, slow sender, then full rate with a long stall
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 6;
          rx_idle_pct = 57;
        end
        1: begin
          tx_idle_pct = 57;
          rx_idle_pct = 6;
        end
        default: begin
          tx_idle_pct   = 0;
          rx_idle_pct   = 0;
          stall_request = 1'b1;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_random_command();
      end
      in_valid <= 1'b0;
      wait_for_readings();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
